/* design/rqfb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqfb_pkg: shared types and constants for the ring queue
// Request and response payloads, action and status codes, and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package rqfb_pkg;

	localparam int LEN_W = 5;
	localparam int ITEM_W = 32;

	typedef enum logic [2:0] {
		ACT_SEND_BACK  = 3'd0,
		ACT_SEND_FRONT = 3'd1,
		ACT_OVERWRITE  = 3'd2,
		ACT_RECEIVE    = 3'd3,
		ACT_PEEK       = 3'd4,
		ACT_CLEAR      = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	typedef enum logic {
		CFG_QUEUE_LENGTH  = 1'b0,
		CFG_COUNTING_ONLY = 1'b1
	} cfg_index_t;

	typedef struct packed {
		action_t            action;
		logic [ITEM_W-1:0]  item_in;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [ITEM_W-1:0]  item_out;
		logic [LEN_W-1:0]   items_waiting;
		logic [LEN_W-1:0]   spaces_free;
	} rsp_t;

	typedef struct packed {
		status_t            status;
		logic               read_ok;
		logic [LEN_W-1:0]   items_waiting;
		logic [LEN_W-1:0]   spaces_free;
	} ctrl_info_t;

endpackage

/* design/rqfb_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqfb_mem: slot store of the ring queue
// One write port and one read port with registered read data that holds
// its value until the next read.
// ----------------------------------------------------------------------------
module rqfb_mem #(
	parameter int DEPTH = 16,
	parameter int ITEM_BITS = 32,
	parameter int IW = 4
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [IW-1:0]        wr_addr,
	input  logic [ITEM_BITS-1:0] wr_data,
	input  logic                 rd_en,
	input  logic [IW-1:0]        rd_addr,
	output logic [ITEM_BITS-1:0] rd_data_s1
);

	logic [ITEM_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

endmodule

/* design/rqfb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqfb_ctrl: queue indices, item count and configuration registers
// Decodes one request per cycle while accept is high, updates the ring state and
// issues the slot write or read that the request needs.
// ----------------------------------------------------------------------------
module rqfb_ctrl #(
	parameter int DEPTH = 16,
	parameter int ITEM_BITS = 32,
	parameter int IW = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  rqfb_pkg::cfg_index_t        cfg_index,
	input  logic [rqfb_pkg::LEN_W-1:0]  cfg_data,
	input  logic                        accept,
	input  rqfb_pkg::req_t              req,
	output rqfb_pkg::ctrl_info_t        info,
	output logic                        wr_en,
	output logic [IW-1:0]               wr_addr,
	output logic [ITEM_BITS-1:0]        wr_data,
	output logic                        rd_en,
	output logic [IW-1:0]               rd_addr
);

	import rqfb_pkg::*;

	localparam int CW = ((IW > LEN_W) ? IW : LEN_W) + 1;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'((DEPTH > 31) ? 31 : DEPTH);
	localparam logic [LEN_W-1:0] LEN_RST = LEN_W'((DEPTH < 16) ? DEPTH : 16);

	logic [IW-1:0]    wr_idx_q, wr_idx_d;
	logic [IW-1:0]    rd_idx_q, rd_idx_d;
	logic [LEN_W-1:0] count_q, count_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic             cnt_only_q, cnt_only_d;
	logic [LEN_W-1:0] len_cfg;
	logic [IW-1:0]    wr_next, rd_next, rd_prev;
	logic [63:0]      item_wide;
	status_t          status;
	logic             read_ok;

	function automatic logic [IW-1:0] next_idx(logic [IW-1:0] i, logic [LEN_W-1:0] len);
		logic [CW-1:0] inc;
		inc = CW'(i) + CW'(1);
		return (inc >= CW'(len)) ? '0 : IW'(inc);
	endfunction

	function automatic logic [IW-1:0] prev_idx(logic [IW-1:0] i, logic [LEN_W-1:0] len);
		logic [IW-1:0] last;
		last = IW'(len - LEN_W'(1));
		return (i == '0 || CW'(i) >= CW'(len)) ? last : i - IW'(1);
	endfunction

	always_comb begin
		len_cfg = cfg_data;
		if (len_cfg == '0) begin
			len_cfg = LEN_W'(1);
		end
		if (len_cfg > LEN_MAX) begin
			len_cfg = LEN_MAX;
		end
	end

	assign wr_next = next_idx(wr_idx_q, len_q);
	assign rd_next = next_idx(rd_idx_q, len_q);
	assign rd_prev = prev_idx(rd_idx_q, len_q);
	assign item_wide = 64'(req.item_in);

	always_comb begin
		wr_idx_d = wr_idx_q;
		rd_idx_d = rd_idx_q;
		count_d = count_q;
		len_d = len_q;
		cnt_only_d = cnt_only_q;
		status = ST_OK;
		read_ok = 1'b0;
		wr_en = 1'b0;
		wr_addr = wr_idx_q;
		wr_data = item_wide[ITEM_BITS-1:0];
		rd_en = 1'b0;
		rd_addr = rd_next;

		if (accept) begin
			case (req.action)
				ACT_SEND_BACK, ACT_SEND_FRONT: begin
					if (count_q >= len_q) begin
						status = ST_FULL;
					end else begin
						if (!cnt_only_q) begin
							wr_en = accept;
							if (req.action == ACT_SEND_BACK) begin
								wr_idx_d = wr_next;
							end else begin
								wr_addr = rd_idx_q;
								rd_idx_d = rd_prev;
							end
						end
						count_d = count_q + LEN_W'(1);
					end
				end
				ACT_OVERWRITE: begin
					if (len_q != LEN_W'(1)) begin
						status = ST_BAD;
					end else begin
						if (!cnt_only_q) begin
							wr_en = accept;
							wr_addr = rd_idx_q;
							rd_idx_d = rd_prev;
						end
						count_d = LEN_W'(1);
					end
				end
				ACT_RECEIVE, ACT_PEEK: begin
					if (count_q == '0) begin
						status = ST_EMPTY;
					end else begin
						if (!cnt_only_q) begin
							read_ok = 1'b1;
							rd_en = accept;
							if (req.action == ACT_RECEIVE) begin
								rd_idx_d = rd_next;
							end
						end
						if (req.action == ACT_RECEIVE) begin
							count_d = count_q - LEN_W'(1);
						end
					end
				end
				ACT_CLEAR: begin
					count_d = '0;
					wr_idx_d = '0;
					rd_idx_d = IW'(len_q - LEN_W'(1));
				end
				default: begin
					status = ST_BAD;
				end
			endcase
		end

		if (cfg_we) begin
			case (cfg_index)
				CFG_QUEUE_LENGTH: begin
					len_d = len_cfg;
					count_d = '0;
					wr_idx_d = '0;
					rd_idx_d = IW'(len_cfg - LEN_W'(1));
				end
				CFG_COUNTING_ONLY: begin
					cnt_only_d = cfg_data[0];
				end
				default: begin
					cnt_only_d = cnt_only_q;
				end
			endcase
		end
	end

	assign info.status = status;
	assign info.read_ok = read_ok;
	assign info.items_waiting = count_d;
	assign info.spaces_free = len_q - count_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= IW'(LEN_RST - LEN_W'(1));
			count_q <= '0;
			len_q <= LEN_RST;
			cnt_only_q <= 1'b0;
		end else if (accept || cfg_we) begin
			wr_idx_q <= wr_idx_d;
			rd_idx_q <= rd_idx_d;
			count_q <= count_d;
			len_q <= len_d;
			cnt_only_q <= cnt_only_d;
		end
	end

endmodule

/* design/ring_queue_front_back_overwrite.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_queue_front_back_overwrite: circular item queue with front sends
// Ring of item slots serving send-to-back, send-to-front, overwrite,
// receive, peek and clear requests, one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req/req_valid/req_ready and responses leave on
//   rsp/rsp_valid/rsp_ready; a transfer happens when valid and ready are
//   both high at a rising edge. Each request yields exactly one response.
//   The configuration port writes queue_length (index 0, which empties the
//   queue) or counting_only (index 1) on any edge with cfg_we high; write
//   it only while no request is in flight.
//   A request is decoded in the cycle it is accepted and the slot memory is
//   read at that edge; the result passes through the middle stage and the
//   response register before it is offered on rsp.
//   One request is taken every cycle while the receiver keeps up; the
//   indices and count are updated in the cycle the request is accepted.
//   A stalled receiver fills the response register and then the middle
//   stage, after which req_ready drops until rsp_ready returns.
//   Reset clears the count and write index, sets the read index to the
//   last slot, the length to 16 (or DEPTH if smaller) and data mode. Slot
//   contents are not reset; a slot is read only when the count is nonzero.
// ----------------------------------------------------------------------------
module ring_queue_front_back_overwrite #(
	parameter int DEPTH = 16,
	parameter int ITEM_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  rqfb_pkg::cfg_index_t        cfg_index,
	input  logic [rqfb_pkg::LEN_W-1:0]  cfg_data,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  rqfb_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output rqfb_pkg::rsp_t              rsp
);

	import rqfb_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                 accept;
	logic                 advance;
	ctrl_info_t           info;
	ctrl_info_t           info_s1;
	logic                 valid_s1;
	logic                 wr_en;
	logic [IW-1:0]        wr_addr;
	logic [ITEM_BITS-1:0] wr_data;
	logic                 rd_en;
	logic [IW-1:0]        rd_addr;
	logic [ITEM_BITS-1:0] rd_data_s1;
	logic [63:0]          rd_wide;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	assign advance = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign accept = req_valid && req_ready;

	rqfb_ctrl #(
		.DEPTH(DEPTH),
		.ITEM_BITS(ITEM_BITS),
		.IW(IW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.accept(accept),
		.req(req),
		.info(info),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr)
	);

	rqfb_mem #(
		.DEPTH(DEPTH),
		.ITEM_BITS(ITEM_BITS),
		.IW(IW)
	) u_mem (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data_s1(rd_data_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
	end

	assign rd_wide = 64'(rd_data_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.status <= info_s1.status;
			rsp_q.item_out <= info_s1.read_ok ? rd_wide[ITEM_W-1:0] : '0;
			rsp_q.items_waiting <= info_s1.items_waiting;
			rsp_q.spaces_free <= info_s1.spaces_free;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
